// ===== sv/ihex_pkg.sv =====
// Shared types, constants and helper functions for the Intel HEX to OMF
// content converter. No dependencies; imported by every other file.
package ihex_pkg;

  // Content record size that forces a close at the start of the next record.
  localparam int unsigned MAX_CONTENT = 49152;
  localparam logic [15:0] CONTENT_LIMIT = 16'(MAX_CONTENT);

  // OMF record constants.
  localparam logic [7:0]  OMF_CONTENT_BASE = 8'd6;
  localparam logic [15:0] OMF_LEN_EXTRA    = 16'd4;
  localparam logic [7:0]  OMF_END_BASE     = 8'd10;

  // Character codes and record layout.
  localparam logic [6:0] CHAR_COLON   = 7'h3a;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_LOWER_Z = 7'h7a;
  localparam logic [6:0] CASE_OFFSET  = 7'h20;
  localparam logic [7:0] ADDR_BYTES   = 8'd2;
  localparam logic [7:0] BAD_DIGIT    = 8'hff;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR  = 2'd1;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_WAIT  = 4'd0,
    PH_LEN   = 4'd1,
    PH_ADDR  = 4'd2,
    PH_TYPE  = 4'd3,
    PH_DATA  = 4'd4,
    PH_CSUM  = 4'd5,
    PH_EADDR = 4'd6,
    PH_ETYPE = 4'd7,
    PH_ECSUM = 4'd8,
    PH_DONE  = 4'd9,
    PH_HALT  = 4'd10
  } phase_t;

  // Result item kinds.
  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_CLOSE    = 2'd1,
    KIND_END      = 2'd2,
    KIND_CSUM_ERR = 2'd3
  } kind_t;

  typedef struct packed {
    logic        override_en;
    logic [15:0] start_addr;
  } ihex_cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] address;
    logic [15:0] data_count;
    logic [7:0]  record_checksum;
    logic        start_warning;
  } ihex_result_t;

  // Map a lower-case letter to upper case; everything else passes.
  function automatic logic [6:0] to_upper(logic [6:0] c);
    logic [6:0] u;
    u = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      u = c - CASE_OFFSET;
    end
    return u;
  endfunction

  // Value of a hex digit; any other character reads as all ones.
  function automatic logic [7:0] hex_value(logic [6:0] c);
    logic [7:0] v;
    v = BAD_DIGIT;
    if (c >= 7'h30 && c <= 7'h39) begin
      v = {1'b0, c - 7'h30};
    end else if (c >= 7'h41 && c <= 7'h46) begin
      v = {1'b0, c - 7'h37};
    end
    return v;
  endfunction

endpackage

// ===== sv/intel_hex_to_omf_content.sv =====
// Top level of the Intel HEX to OMF content converter: handshakes,
// configuration registers, input and result registers.
// Depends on ihex_pkg and ihex_parser.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------------
//   in_     | in        | in_valid/in_stall  | in_char_in
//   out_    | out       | out_valid/out_stall| kind, data_byte, address, data_count,
//           |           |                    | record_checksum, start_warning
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One character per cycle unless stalled: a character is registered, parsed by
// combinational logic and its result, if any, is loaded into the output register.
// The input register stalls only while a result waits in the output register
// and out_stall is high.
// Reset is synchronous and active low; cfg_ready is always high.
module intel_hex_to_omf_content (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_address,
  output logic [15:0] out_data_count,
  output logic [7:0]  out_record_checksum,
  output logic        out_start_warning,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import ihex_pkg::*;

  ihex_cfg_t    cfg_r;
  logic         in_vld_r, in_vld_nxt;
  logic [7:0]   in_char_r;
  logic         out_valid_r, out_valid_nxt;
  ihex_result_t out_res_r;
  logic         advance;
  logic         step;
  logic         res_valid;
  ihex_result_t res;

  // Configuration writes.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_OVERRIDE_EN) begin
        cfg_r.override_en <= cfg_data[0];
      end else if (cfg_index == CFG_START_ADDR) begin
        cfg_r.start_addr <= cfg_data;
      end
    end
  end

  // The parse step runs unless a result is blocked in the output register.
  assign advance  = !(out_valid_r && out_stall);
  assign step     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  // Input register.
  assign in_vld_nxt = in_stall ? in_vld_r : in_valid;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_char_in;
    end
  end

  ihex_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .char_i      (in_char_r),
    .cfg_i       (cfg_r),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register.
  assign out_valid_nxt = advance ? (step && res_valid) : out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_res_r.kind;
  assign out_data_byte       = out_res_r.data_byte;
  assign out_address         = out_res_r.address;
  assign out_data_count      = out_res_r.data_count;
  assign out_record_checksum = out_res_r.record_checksum;
  assign out_start_warning   = out_res_r.start_warning;

endmodule

// ===== sv/ihex_parser.sv =====
// Character-level Intel HEX record parser and OMF content tracker.
// Holds the parse state and produces at most one result per character.
// Depends on ihex_pkg.
module ihex_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  input  logic [7:0]            char_i,
  input  ihex_pkg::ihex_cfg_t   cfg_i,
  output logic                  res_valid_o,
  output ihex_pkg::ihex_result_t res_o
);
  import ihex_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        pending_r, pending_nxt;
  logic [3:0]  hn_r, hn_nxt;
  logic [7:0]  record_sum_r, record_sum_nxt;
  logic [7:0]  record_len_r, record_len_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] record_addr_r, record_addr_nxt;
  logic [15:0] next_addr_r, next_addr_nxt;
  logic [15:0] content_start_r, content_start_nxt;
  logic [15:0] content_count_r, content_count_nxt;
  logic [7:0]  content_sum_r, content_sum_nxt;

  logic [6:0]  c;
  logic [7:0]  n;
  logic [7:0]  b;
  logic [7:0]  sum_upd;
  logic [7:0]  left_dec;
  logic [15:0] addr_shift;
  logic [15:0] close_len;
  logic [7:0]  close_sum;
  logic [15:0] end_start;
  logic [7:0]  end_sum;
  logic        byte_path;
  ihex_result_t close_res;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_WAIT;
      pending_r       <= 1'b0;
      hn_r            <= '0;
      record_sum_r    <= '0;
      record_len_r    <= '0;
      bytes_left_r    <= '0;
      record_addr_r   <= '0;
      next_addr_r     <= '0;
      content_start_r <= '0;
      content_count_r <= '0;
      content_sum_r   <= '0;
    end else begin
      phase_r         <= phase_nxt;
      pending_r       <= pending_nxt;
      hn_r            <= hn_nxt;
      record_sum_r    <= record_sum_nxt;
      record_len_r    <= record_len_nxt;
      bytes_left_r    <= bytes_left_nxt;
      record_addr_r   <= record_addr_nxt;
      next_addr_r     <= next_addr_nxt;
      content_start_r <= content_start_nxt;
      content_count_r <= content_count_nxt;
      content_sum_r   <= content_sum_nxt;
    end
  end

  // Character decode and the byte assembled from the stored high nibble.
  assign c          = to_upper(char_i[6:0]);
  assign n          = hex_value(c);
  assign b          = {hn_r, 4'h0} + n;
  assign sum_upd    = record_sum_r + b;
  assign left_dec   = bytes_left_r - 8'd1;
  assign addr_shift = {record_addr_r[7:0], b};

  // Close item for the content record built so far.
  assign close_len = content_count_r + OMF_LEN_EXTRA;
  assign close_sum = OMF_CONTENT_BASE + close_len[7:0] + close_len[15:8]
                   + content_start_r[7:0] + content_start_r[15:8] + content_sum_r;
  always_comb begin
    close_res                 = '0;
    close_res.kind            = KIND_CLOSE;
    close_res.address         = content_start_r;
    close_res.data_count      = content_count_r;
    close_res.record_checksum = 8'd0 - close_sum;
  end

  // Module start for the end record.
  assign end_start = cfg_i.override_en ? cfg_i.start_addr : record_addr_r;
  assign end_sum   = OMF_END_BASE + end_start[7:0] + end_start[15:8];

  // Next state and result.
  always_comb begin
    phase_nxt         = phase_r;
    pending_nxt       = pending_r;
    hn_nxt            = hn_r;
    record_sum_nxt    = record_sum_r;
    record_len_nxt    = record_len_r;
    bytes_left_nxt    = bytes_left_r;
    record_addr_nxt   = record_addr_r;
    next_addr_nxt     = next_addr_r;
    content_start_nxt = content_start_r;
    content_count_nxt = content_count_r;
    content_sum_nxt   = content_sum_r;
    res_valid_o       = 1'b0;
    res_o             = '0;
    byte_path         = 1'b0;

    if (step_i) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (c == CHAR_COLON) begin
            record_sum_nxt = '0;
            pending_nxt    = 1'b0;
            phase_nxt      = PH_LEN;
          end
        end
        PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM,
        PH_EADDR, PH_ETYPE, PH_ECSUM: begin
          byte_path = 1'b1;
        end
        default: begin
          // Done, halted or an unused code: characters are ignored.
        end
      endcase
    end

    if (byte_path) begin
      if (!pending_r) begin
        hn_nxt      = n[3:0];
        pending_nxt = 1'b1;
      end else begin
        pending_nxt    = 1'b0;
        record_sum_nxt = sum_upd;
        unique case (phase_r)
          PH_LEN: begin
            record_len_nxt  = b;
            bytes_left_nxt  = ADDR_BYTES;
            record_addr_nxt = '0;
            if (b != 8'd0) begin
              phase_nxt = PH_ADDR;
            end else begin
              // End-of-file record: flush the open content record.
              res_valid_o       = (content_count_r != 16'd0);
              res_o             = close_res;
              content_count_nxt = '0;
              content_sum_nxt   = '0;
              phase_nxt         = PH_EADDR;
            end
          end
          PH_ADDR: begin
            record_addr_nxt = addr_shift;
            bytes_left_nxt  = left_dec;
            if (left_dec == 8'd0) begin
              // Start a new content record on a gap or when the limit is hit.
              if (next_addr_r != addr_shift || content_count_r >= CONTENT_LIMIT) begin
                res_valid_o       = (content_count_r != 16'd0);
                res_o             = close_res;
                content_count_nxt = '0;
                content_sum_nxt   = '0;
                content_start_nxt = addr_shift;
                next_addr_nxt     = addr_shift;
              end
              phase_nxt = PH_TYPE;
            end
          end
          PH_TYPE: begin
            bytes_left_nxt = record_len_r;
            phase_nxt      = PH_DATA;
          end
          PH_DATA: begin
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_DATA;
            res_o.data_byte   = b;
            res_o.address     = next_addr_r;
            next_addr_nxt     = next_addr_r + 16'd1;
            content_count_nxt = content_count_r + 16'd1;
            content_sum_nxt   = content_sum_r + b;
            bytes_left_nxt    = left_dec;
            if (left_dec == 8'd0) begin
              phase_nxt = PH_CSUM;
            end
          end
          PH_CSUM: begin
            if (sum_upd != 8'd0) begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_CSUM_ERR;
              phase_nxt   = PH_HALT;
            end else begin
              phase_nxt = PH_WAIT;
            end
          end
          PH_EADDR: begin
            record_addr_nxt = addr_shift;
            bytes_left_nxt  = left_dec;
            if (left_dec == 8'd0) begin
              phase_nxt = PH_ETYPE;
            end
          end
          PH_ETYPE: begin
            phase_nxt = PH_ECSUM;
          end
          PH_ECSUM: begin
            res_valid_o           = 1'b1;
            res_o.kind            = KIND_END;
            res_o.address         = end_start;
            res_o.record_checksum = 8'd0 - end_sum;
            res_o.start_warning   = !cfg_i.override_en && (sum_upd != 8'd0);
            phase_nxt             = PH_DONE;
          end
          default: begin
            phase_nxt = PH_HALT;
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/ihex_checker.sv =====
// Port-level checks for the Intel HEX to OMF content converter, bound to
// the top level. Depends on ihex_pkg and intel_hex_to_omf_content.
module ihex_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic [15:0] out_address,
  input logic [15:0] out_data_count,
  input logic [7:0]  out_record_checksum,
  input logic        out_start_warning
);
  import ihex_pkg::*;

  logic seen_stop_r;
  logic stop_xfer;

  // A module end or checksum error transfer ends all further output.
  assign stop_xfer = out_valid && !out_stall
                     && (out_kind == KIND_END || out_kind == KIND_CSUM_ERR);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_stop_r <= 1'b0;
    end else if (stop_xfer) begin
      seen_stop_r <= 1'b1;
    end
  end

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid
      && $stable({out_kind, out_data_byte, out_address, out_data_count,
                  out_record_checksum, out_start_warning}))
    else $error("result changed while stalled");

  // Input is only held back by a blocked result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A closed content record is never empty.
  a_close_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CLOSE |-> out_data_count != 16'd0)
    else $error("empty content record closed");

  // Nothing follows a module end or checksum error.
  a_no_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    seen_stop_r |-> !out_valid)
    else $error("result after module end or checksum error");

  // Data bytes carry no count, checksum or warning.
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_data_count == 16'd0
      && out_record_checksum == 8'd0 && !out_start_warning)
    else $error("data byte with stray fields");

endmodule

bind intel_hex_to_omf_content ihex_checker u_ihex_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_kind            (out_kind),
  .out_data_byte       (out_data_byte),
  .out_address         (out_address),
  .out_data_count      (out_data_count),
  .out_record_checksum (out_record_checksum),
  .out_start_warning   (out_start_warning)
);
